[sv/iq_phase_rotation_estimator_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the phase rotation estimator
// Clocked checks with synchronous reset masking.
// ---------------------------------------------------------------------------
`ifndef IQ_PHASE_ROTATION_ESTIMATOR_ASSERT_SVH
`define IQ_PHASE_ROTATION_ESTIMATOR_ASSERT_SVH

// Property holds at every clock edge outside reset
`define IQPRE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// When cond holds, prop holds in the next cycle
`define IQPRE_ASSERT_NEXT(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/iqpre_pkg.sv]
// ---------------------------------------------------------------------------
// iqpre_pkg
// Constants, types and the CORDIC angle table of the phase rotation estimator.
// ---------------------------------------------------------------------------
`default_nettype none

package iqpre_pkg;

   // Sizing
   localparam int SAMPLE_WIDTH   = 16;
   localparam int MAX_SAMPLES    = 16;
   localparam int CORDIC_STEPS   = 14;
   localparam int ANGLE_TABLE_LEN = 20;
   localparam int CORDIC_RUN     = (CORDIC_STEPS < ANGLE_TABLE_LEN) ?
                                   CORDIC_STEPS : ANGLE_TABLE_LEN;
   localparam int STEP_BITS      = (CORDIC_RUN > 1) ? $clog2(CORDIC_RUN) : 1;
   localparam int XY_WIDTH       = SAMPLE_WIDTH + 6;
   localparam int ANGLE_BITS     = 16;
   localparam int CONFIG_WIDTH   = 5;
   localparam int COUNT_WIDTH    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_WIDTH      = ANGLE_BITS + $clog2(MAX_SAMPLES);
   localparam int DIV_BITS       = $clog2(SUM_WIDTH);
   localparam int OUT_WIDTH      = 16;
   localparam int PROD_WIDTH     = OUT_WIDTH + 7;

   localparam logic [CONFIG_WIDTH-1:0] SAMPLE_COUNT_RESET = CONFIG_WIDTH'(7);
   localparam logic [ANGLE_BITS-1:0]   HALF_TURN = 16'h8000;
   localparam logic signed [PROD_WIDTH-1:0] SCALE_FACTOR = PROD_WIDTH'(45);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // CORDIC unit status
   typedef struct packed {
      logic                  done;
      logic [ANGLE_BITS-1:0] phase;
   } cordic_result_type;

   // Divider unit status
   typedef struct packed {
      logic                 done;
      logic [SUM_WIDTH-1:0] quotient;
   } div_result_type;

   // atan(2^-k) in binary angle units, rounded
   function automatic logic [ANGLE_BITS-1:0] angle_entry(input logic [4:0] k);
      logic [ANGLE_BITS-1:0] a;
      case (k)
         5'd0:  a = 16'd8192;
         5'd1:  a = 16'd4836;
         5'd2:  a = 16'd2555;
         5'd3:  a = 16'd1297;
         5'd4:  a = 16'd651;
         5'd5:  a = 16'd326;
         5'd6:  a = 16'd163;
         5'd7:  a = 16'd81;
         5'd8:  a = 16'd41;
         5'd9:  a = 16'd20;
         5'd10: a = 16'd10;
         5'd11: a = 16'd5;
         5'd12: a = 16'd3;
         5'd13: a = 16'd1;
         5'd14: a = 16'd1;
         default: a = 16'd0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

[sv/iqpre_cordic.sv]
// ---------------------------------------------------------------------------
// iqpre_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle, returns atan2(q, i)
// in 16-bit binary angle units.
// ---------------------------------------------------------------------------
`default_nettype none

module iqpre_cordic
   import iqpre_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
   output cordic_result_type                   result
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [STEP_BITS-1:0]       step_ff;
   logic signed [XY_WIDTH-1:0] x_ff;
   logic signed [XY_WIDTH-1:0] y_ff;
   logic [ANGLE_BITS-1:0]      z_ff;
   logic                       zero_ff;

   logic signed [XY_WIDTH-1:0] x_start;
   logic signed [XY_WIDTH-1:0] y_start;
   logic signed [XY_WIDTH-1:0] dx;
   logic signed [XY_WIDTH-1:0] dy;
   logic [ANGLE_BITS-1:0]      angle;

   // Scale inputs by 8 into the working width
   assign x_start = {{(XY_WIDTH-SAMPLE_WIDTH-3){i_sample[SAMPLE_WIDTH-1]}}, i_sample, 3'b000};
   assign y_start = {{(XY_WIDTH-SAMPLE_WIDTH-3){q_sample[SAMPLE_WIDTH-1]}}, q_sample, 3'b000};

   // Shifted terms and table angle for this step
   assign dx    = x_ff >>> step_ff;
   assign dy    = y_ff >>> step_ff;
   assign angle = angle_entry(5'(step_ff));

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_BITS'(CORDIC_RUN - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Datapath: left half-plane folded onto the right, then micro-rotations
   always_ff @(posedge clock) begin
      if (start) begin
         zero_ff <= (i_sample == '0) && (q_sample == '0);
         if (i_sample[SAMPLE_WIDTH-1]) begin
            x_ff <= -x_start;
            y_ff <= -y_start;
            z_ff <= HALF_TURN;
         end else begin
            x_ff <= x_start;
            y_ff <= y_start;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         if (!y_ff[XY_WIDTH-1]) begin
            x_ff <= x_ff + dy;
            y_ff <= y_ff - dx;
            z_ff <= z_ff + angle;
         end else begin
            x_ff <= x_ff - dy;
            y_ff <= y_ff + dx;
            z_ff <= z_ff - angle;
         end
      end
   end

   assign result.done  = done_ff;
   assign result.phase = zero_ff ? '0 : z_ff;

endmodule

`default_nettype wire

[sv/iqpre_divider.sv]
// ---------------------------------------------------------------------------
// iqpre_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module iqpre_divider
   import iqpre_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SUM_WIDTH-1:0]   dividend,
   input  wire logic [COUNT_WIDTH-1:0] divisor,
   output div_result_type              result
);

   logic                   busy_ff;
   logic                   done_ff;
   logic [DIV_BITS-1:0]    count_ff;
   logic [SUM_WIDTH-1:0]   quo_ff;
   logic [COUNT_WIDTH-1:0] rem_ff;
   logic [COUNT_WIDTH-1:0] div_ff;

   logic [COUNT_WIDTH:0]   trial;
   logic                   fits;

   // Shift in the next dividend bit and compare
   assign trial = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign fits  = trial >= {1'b0, div_ff};

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            if (count_ff == DIV_BITS'(SUM_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_WIDTH-2:0], fits};
         rem_ff <= fits ? COUNT_WIDTH'(trial - {1'b0, div_ff}) : trial[COUNT_WIDTH-1:0];
      end
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

`default_nettype wire

[sv/iq_phase_rotation_estimator.sv]
// ---------------------------------------------------------------------------
// iq_phase_rotation_estimator
// Mean phase step of a window of I/Q samples, scaled to 1/128 degree units.
// ---------------------------------------------------------------------------
// An item that does not close its window keeps req_stall high after acceptance
// through the load, 14 CORDIC steps and the window update. A window-closing
// item also holds the input through divider start, 20 divider steps, mean,
// scaling and the output register load, which sets rsp_valid; that load waits
// while a previous result is stalled.
// Reset (synchronous): sample_count to 7, window state cleared, no result.
`default_nettype none

module iq_phase_rotation_estimator
   import iqpre_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Sample input
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_i_sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_q_sample,
   // Result output
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic signed [OUT_WIDTH-1:0]    rsp_mean_step,
   // Configuration
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [CONFIG_WIDTH-1:0]        csr_sample_count
);

   state_type                     state_ff;
   state_type                     state_in;

   logic [CONFIG_WIDTH-1:0]       sample_count_ff;
   logic [ANGLE_BITS-1:0]         previous_phase_ff;
   logic signed [SUM_WIDTH-1:0]   difference_sum_ff;
   logic [COUNT_WIDTH-1:0]        samples_seen_ff;
   logic                          negative_ff;
   logic signed [OUT_WIDTH-1:0]   mean_ff;
   logic signed [PROD_WIDTH-1:0]  product_ff;
   logic                          rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0]   rsp_phase_ff;

   logic                          req_accept;
   logic                          rsp_free;
   logic                          div_start;
   logic                          emit_load;
   logic [COUNT_WIDTH-1:0]        count_eff;
   logic [COUNT_WIDTH-1:0]        seen_in;
   logic [ANGLE_BITS-1:0]         diff;
   logic signed [SUM_WIDTH-1:0]   sum_in;
   logic [SUM_WIDTH-1:0]          magnitude;
   logic signed [OUT_WIDTH-1:0]   mean_in;
   logic signed [PROD_WIDTH-1:0]  product_round;
   cordic_result_type             cordic_res;
   div_result_type                div_res;

   // Handshakes
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Sample count register
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         sample_count_ff <= csr_sample_count;
      end
   end

   // Clamp the window length to the supported range
   always_comb begin
      if (sample_count_ff < CONFIG_WIDTH'(2)) begin
         count_eff = COUNT_WIDTH'(2);
      end else if (32'(sample_count_ff) > MAX_SAMPLES) begin
         count_eff = COUNT_WIDTH'(MAX_SAMPLES);
      end else begin
         count_eff = COUNT_WIDTH'(sample_count_ff);
      end
   end

   // Phase unit
   iqpre_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .i_sample (req_i_sample),
      .q_sample (req_q_sample),
      .result   (cordic_res)
   );

   // Wrapped phase difference and window bookkeeping
   assign diff    = cordic_res.phase - previous_phase_ff;
   assign sum_in  = (samples_seen_ff != '0) ?
                    difference_sum_ff + {{(SUM_WIDTH-ANGLE_BITS){diff[ANGLE_BITS-1]}}, diff} :
                    difference_sum_ff;
   assign seen_in = samples_seen_ff + 1'b1;

   // Mean divider on the magnitude of the sum
   assign magnitude = difference_sum_ff[SUM_WIDTH-1] ?
                      SUM_WIDTH'(-difference_sum_ff) : SUM_WIDTH'(difference_sum_ff);

   iqpre_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (magnitude),
      .divisor  (count_eff - 1'b1),
      .result   (div_res)
   );

   // Signed, saturated mean
   always_comb begin
      if (negative_ff) begin
         if (div_res.quotient > SUM_WIDTH'(32768)) begin
            mean_in = OUT_WIDTH'(-32768);
         end else begin
            mean_in = OUT_WIDTH'(-div_res.quotient);
         end
      end else begin
         if (div_res.quotient > SUM_WIDTH'(32767)) begin
            mean_in = OUT_WIDTH'(32767);
         end else begin
            mean_in = OUT_WIDTH'(div_res.quotient);
         end
      end
   end

   // Divide by 64 truncating toward zero
   assign product_round = product_ff + (product_ff[PROD_WIDTH-1] ?
                          PROD_WIDTH'(63) : PROD_WIDTH'(0));

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      emit_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_res.done) begin
               state_in = (seen_in >= count_eff) ? ST_DIV_START : ST_IDLE;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               emit_load = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Window state
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_phase_ff <= '0;
         difference_sum_ff <= '0;
         samples_seen_ff   <= '0;
      end else if ((state_ff == ST_CORDIC) && cordic_res.done) begin
         previous_phase_ff <= cordic_res.phase;
         difference_sum_ff <= sum_in;
         samples_seen_ff   <= seen_in;
      end else if (div_start) begin
         difference_sum_ff <= '0;
         samples_seen_ff   <= '0;
      end
   end

   // Result datapath
   always_ff @(posedge clock) begin
      if (div_start) begin
         negative_ff <= difference_sum_ff[SUM_WIDTH-1];
      end
      if ((state_ff == ST_DIV_WAIT) && div_res.done) begin
         mean_ff <= mean_in;
      end
      if (state_ff == ST_SCALE) begin
         product_ff <= PROD_WIDTH'(mean_ff) * SCALE_FACTOR;
      end
      if (emit_load) begin
         rsp_phase_ff <= product_round[OUT_WIDTH+5:6];
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean_step = rsp_phase_ff;

   // Checks
`include "iq_phase_rotation_estimator_assert.svh"

   `IQPRE_ASSERT(a_cordic_done_owned, clock, reset,
      !cordic_res.done || (state_ff == ST_CORDIC), "CORDIC finished outside its state")
   `IQPRE_ASSERT(a_div_done_owned, clock, reset,
      !div_res.done || (state_ff == ST_DIV_WAIT), "divider finished outside its state")
   `IQPRE_ASSERT(a_seen_bound, clock, reset,
      32'(samples_seen_ff) <= MAX_SAMPLES, "sample counter past window limit")
   `IQPRE_ASSERT_NEXT(a_no_overwrite, clock, reset,
      (state_ff == ST_EMIT) && rsp_valid_ff && rsp_stall,
      $stable(rsp_mean_step) && rsp_valid, "pending result overwritten")

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Phase rotation estimator regression
// Sends I/Q samples through the estimator and checks every mean step
// item against a local CORDIC and windowed-mean predictor. A short
// directed table runs first, then random tones, extremes and noise across
// several window lengths with random idling on both sides of the block.
// ---------------------------------------------------------------------------

module testbench;
   import iqpre_pkg::*;

   // Stimulus table row kinds
   typedef enum logic {
      ROW_SAMPLE,
      ROW_CONFIG
   } row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic signed [SAMPLE_WIDTH-1:0]  i_val;
      logic signed [SAMPLE_WIDTH-1:0]  q_val;
      logic                            pinned;
      logic signed [OUT_WIDTH-1:0]     pinned_val;
      logic [CONFIG_WIDTH-1:0]         count_val;
   } stim_row_type;

   localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = 16'sh8000;
   localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = 16'sh7FFF;
   localparam int LUT_LEN          = 20;
   localparam int SETTLE_CYCLES    = 64;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT      = 4000;
   localparam int ITEMS_PER_PHASE  = 36;
   localparam int PHASE_COUNT      = 12;
   localparam int PRESSURE_PHASE   = 5;
   localparam int REPORT_LIMIT     = 10;
   localparam real PI              = 3.14159265358979;

   // atan(2^-k) in binary angle units
   localparam int ATAN_LUT [0:LUT_LEN-1] = '{
      8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0, 0, 0, 0, 0
   };

   // Window length per random phase; out-of-range values included
   localparam logic [CONFIG_WIDTH-1:0] PHASE_COUNTS [0:PHASE_COUNT-1] = '{
      5'd2, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2, 5'd1, 5'd7, 5'd3, 5'd12, 5'd16, 5'd4
   };

   // Directed table; pinned rows carry an obvious result
   localparam int DIR_ROWS = 28;
   localparam stim_row_type DIRECTED [0:DIR_ROWS-1] = '{
      // zero vectors right after reset, default window of seven
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd0, 1'b1, 16'sd0, 5'd0},
      // pairs: constant extreme, opposite corners, axes, half-turn wrap
      '{ROW_CONFIG, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd2},
      '{ROW_SAMPLE, SMAX, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, SMAX, 16'sd0, 1'b1, 16'sd0, 5'd0},
      '{ROW_SAMPLE, SMIN, SMIN, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, SMAX, SMAX, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, SMAX, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, SMIN, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, SMIN, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, -16'sd1, -16'sd1, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, SMIN, 16'sd1, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, SMIN, -16'sd1, 1'b0, 16'sd0, 5'd0},
      // count below the minimum acts as two
      '{ROW_CONFIG, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd100, -16'sd5, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, -16'sd7, 16'sd300, 1'b0, 16'sd0, 5'd0},
      // quarter-turn steps, then the window shrinks mid-way (saturated mean)
      '{ROW_CONFIG, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd7},
      '{ROW_SAMPLE, 16'sd1000, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, 16'sd1000, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, -16'sd1000, 16'sd0, 1'b0, 16'sd0, 5'd0},
      '{ROW_SAMPLE, 16'sd0, -16'sd1000, 1'b0, 16'sd0, 5'd0},
      '{ROW_CONFIG, 16'sd0, 16'sd0, 1'b0, 16'sd0, 5'd2},
      '{ROW_SAMPLE, 16'sd1000, 16'sd0, 1'b0, 16'sd0, 5'd0}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_i_sample;
   logic signed [SAMPLE_WIDTH-1:0] req_q_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [OUT_WIDTH-1:0]   rsp_mean_step;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CONFIG_WIDTH-1:0]       csr_sample_count;

   // Predictor state
   logic [CONFIG_WIDTH-1:0]       window_len = 5'd7;
   logic [15:0]                   last_phase = 16'd0;
   int                            step_sum   = 0;
   int                            seen_count = 0;
   logic signed [OUT_WIDTH-1:0]   rotation_q [$];

   logic signed [OUT_WIDTH-1:0]   expected_rotation;
   int                            fail_count      = 0;
   int                            quiet_cycles    = 0;
   logic                          sender_idling   = 1'b1;
   logic                          receiver_idling = 1'b1;
   logic                          hold_request    = 1'b0;

   iq_phase_rotation_estimator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_i_sample       (req_i_sample),
      .req_q_sample       (req_q_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean_step      (rsp_mean_step),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_sample_count   (csr_sample_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // CORDIC vectoring phase in binary angle units
   function automatic logic [15:0] vector_angle(input logic signed [SAMPLE_WIDTH-1:0] i_val,
                                                input logic signed [SAMPLE_WIDTH-1:0] q_val);
      longint x, y, dx, dy;
      int     z;
      if (i_val == 0 && q_val == 0) return 16'd0;
      x = longint'(i_val) * 8;
      y = longint'(q_val) * 8;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32768;
      end
      for (int k = 0; k < CORDIC_STEPS && k < LUT_LEN; k++) begin
         dx = x >>> k;
         dy = y >>> k;
         if (y >= 0) begin
            x = x + dy;
            y = y - dx;
            z = z + ATAN_LUT[k];
         end else begin
            x = x - dy;
            y = y + dx;
            z = z - ATAN_LUT[k];
         end
      end
      return z[15:0];
   endfunction

   // Accumulate one sample; report a rotation when the window closes
   task automatic predict_rotation(input logic signed [SAMPLE_WIDTH-1:0] i_val,
                                   input logic signed [SAMPLE_WIDTH-1:0] q_val,
                                   output logic closes,
                                   output logic signed [OUT_WIDTH-1:0] rotation);
      int          span;
      int          mean;
      int          scaled;
      logic [15:0] phase;
      logic [15:0] delta;
      span = int'(window_len);
      if (span < 2) span = 2;
      if (span > MAX_SAMPLES) span = MAX_SAMPLES;
      phase = vector_angle(i_val, q_val);
      if (seen_count > 0) begin
         delta    = phase - last_phase;
         step_sum = step_sum + int'(signed'(delta));
      end
      last_phase = phase;
      seen_count++;
      closes   = 1'b0;
      rotation = '0;
      if (seen_count >= span) begin
         mean = step_sum / (span - 1);
         if (mean > 32767) mean = 32767;
         if (mean < -32768) mean = -32768;
         scaled     = (mean * 45) / 64;
         rotation   = scaled[OUT_WIDTH-1:0];
         closes     = 1'b1;
         step_sum   = 0;
         seen_count = 0;
      end
   endtask

   // Offer one sample, hold it until taken, then predict
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] i_val,
                              input logic signed [SAMPLE_WIDTH-1:0] q_val,
                              input logic pinned,
                              input logic signed [OUT_WIDTH-1:0] pinned_val);
      logic                        closes;
      logic signed [OUT_WIDTH-1:0] rotation;
      if (sender_idling && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_i_sample <= i_val;
      req_q_sample <= q_val;
      do @(posedge clock); while (req_stall);
      predict_rotation(i_val, q_val, closes, rotation);
      if (closes) rotation_q.push_back(pinned ? pinned_val : rotation);
   endtask

   // Drain outstanding results, then let a non-closing sample finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rotation_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sample_count(input logic [CONFIG_WIDTH-1:0] value);
      csr_valid        <= 1'b1;
      csr_sample_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      window_len = value;
   endtask

   // Result side: random stall bursts, plus one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
            hold_request = 1'b0;
         end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotation_q.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected mean step item: got %0d", rsp_mean_step);
            fail_count++;
         end else begin
            expected_rotation = rotation_q.pop_front();
            if (rsp_mean_step !== expected_rotation) begin
               if (fail_count < REPORT_LIMIT)
                  $display("mean step mismatch: expected %0d, got %0d",
                           expected_rotation, rsp_mean_step);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("iq_phase_rotation_estimator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Main sequence
   initial begin
      logic signed [SAMPLE_WIDTH-1:0] si;
      logic signed [SAMPLE_WIDTH-1:0] sq;
      real                            tone_angle;
      real                            tone_step;
      real                            tone_amp;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_i_sample     = '0;
      req_q_sample     = '0;
      csr_valid        = 1'b0;
      csr_sample_count = '0;
      tone_angle       = 0.0;
      tone_step        = 0.3;
      tone_amp         = 20000.0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIRECTED[r].kind == ROW_CONFIG) begin
            wait_idle();
            write_sample_count(DIRECTED[r].count_val);
         end else begin
            send_sample(DIRECTED[r].i_val, DIRECTED[r].q_val,
                        DIRECTED[r].pinned, DIRECTED[r].pinned_val);
         end
      end

      // Random phases over several window lengths
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         write_sample_count(PHASE_COUNTS[p]);
         sender_idling   = (p < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
         receiver_idling = (p < PHASE_COUNT - 2) && ($urandom_range(0, 3) != 0);
         if (p == PRESSURE_PHASE) hold_request = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // occasionally start a new tone
            if ($urandom_range(0, 7) == 0) begin
               tone_amp   = $urandom_range(1, 32767);
               tone_angle = $urandom_range(0, 65535);
               tone_angle = tone_angle * PI / 32768.0;
               tone_step  = $urandom_range(0, 65535);
               tone_step  = (tone_step - 32768.0) * PI / 32768.0;
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  tone_angle = tone_angle + tone_step;
                  si = SAMPLE_WIDTH'($rtoi(tone_amp * $cos(tone_angle)));
                  sq = SAMPLE_WIDTH'($rtoi(tone_amp * $sin(tone_angle)));
               end
               6, 7: begin
                  si = SAMPLE_WIDTH'($urandom_range(0, 65535));
                  sq = SAMPLE_WIDTH'($urandom_range(0, 65535));
               end
               8: begin
                  case ($urandom_range(0, 3))
                     0: si = SMIN;
                     1: si = SMAX;
                     2: si = 16'sd0;
                     default: si = -16'sd1;
                  endcase
                  case ($urandom_range(0, 3))
                     0: sq = SMIN;
                     1: sq = SMAX;
                     2: sq = 16'sd0;
                     default: sq = -16'sd1;
                  endcase
               end
               default: begin
                  // zero vector or a tiny one near the origin
                  si = $urandom_range(0, 1) ? 16'sd0 :
                       SAMPLE_WIDTH'(int'($urandom_range(0, 4)) - 2);
                  sq = $urandom_range(0, 1) ? 16'sd0 :
                       SAMPLE_WIDTH'(int'($urandom_range(0, 4)) - 2);
               end
            endcase
            send_sample(si, sq, 1'b0, '0);
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("iq_phase_rotation_estimator regression: pass");
      else
         $display("iq_phase_rotation_estimator regression: fail");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/iqpre_pkg.sv
sv/iqpre_cordic.sv
sv/iqpre_divider.sv
sv/iq_phase_rotation_estimator.sv
tb/sv/testbench.sv
